FILE: design/tpg_pkg.sv
// ----------------------------------------------------------------------------
// tpg_pkg - shared types and constants for the target point grouping table
// Beat formats, memory entry formats, status and kind codes, sizes.
// ----------------------------------------------------------------------------
package tpg_pkg;

  // Table geometry (fixed by the beat field widths)
  localparam int NUM_SLOTS       = 32;
  localparam int POINTS_PER_SLOT = 64;

  localparam int SLOT_W     = $clog2(NUM_SLOTS);            // slot index
  localparam int PT_W       = $clog2(POINTS_PER_SLOT);      // point index
  localparam int SLOT_CNT_W = $clog2(NUM_SLOTS + 1);        // slots in use
  localparam int PT_CNT_W   = $clog2(POINTS_PER_SLOT + 1);  // points in slot
  localparam int PT_ADDR_W  = SLOT_W + PT_W;
  localparam int SCAN_W     = (PT_CNT_W > SLOT_CNT_W) ? PT_CNT_W : SLOT_CNT_W;
  localparam int DUP_W      = 16;

  localparam logic [DUP_W-1:0] DUP_MAX = '1;

  // Item kinds
  localparam logic [1:0] KIND_PLOT  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Result status codes
  localparam logic [3:0] ST_NEW_TARGET = 4'd0;
  localparam logic [3:0] ST_PT_ADDED   = 4'd1;
  localparam logic [3:0] ST_DUP_REPL   = 4'd2;
  localparam logic [3:0] ST_DUP_KEPT   = 4'd3;
  localparam logic [3:0] ST_NO_SLOT    = 4'd4;
  localparam logic [3:0] ST_PTS_FULL   = 4'd5;
  localparam logic [3:0] ST_CLEARED    = 4'd6;
  localparam logic [3:0] ST_READ_OK    = 4'd7;
  localparam logic [3:0] ST_READ_BAD   = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target_id;
    logic [31:0] time_ms;
    logic [23:0] range_m;
    logic [15:0] azimuth;
    logic [4:0]  read_slot;
    logic [5:0]  read_point;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [4:0]  slot_index;
    logic [5:0]  point_index;
    logic [6:0]  point_count;
    logic [15:0] duplicate_count;
    logic [5:0]  target_count;
    logic [15:0] out_target_id;
    logic [31:0] out_time_ms;
    logic [23:0] out_range_m;
    logic [15:0] out_azimuth;
  } out_item_t;

  typedef struct packed {
    logic [15:0]         id;
    logic [PT_CNT_W-1:0] cnt;
    logic [DUP_W-1:0]    dup;
  } slot_entry_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [23:0] range_m;
    logic [15:0] azimuth;
  } point_entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_entry_t       wdata;
    logic [SLOT_W-1:0] raddr;
  } slot_req_t;

  typedef struct packed {
    logic                 we;
    logic [PT_ADDR_W-1:0] waddr;
    point_entry_t         wdata;
    logic [PT_ADDR_W-1:0] raddr;
  } point_req_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SRCH,
    SEQ_PSCAN,
    SEQ_RD_SLOT,
    SEQ_RD_SLOT_W,
    SEQ_RD_PT_W,
    SEQ_DONE
  } seq_state_t;

endpackage

FILE: design/tpg_slot_mem.sv
// ----------------------------------------------------------------------------
// tpg_slot_mem - per-slot table (id, point count, duplicate count)
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tpg_slot_mem (
  input  logic                 clk,
  input  tpg_pkg::slot_req_t   req_i,
  output tpg_pkg::slot_entry_t rdata_o
);

  tpg_pkg::slot_entry_t mem [tpg_pkg::NUM_SLOTS];
  tpg_pkg::slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_r <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_r;

endmodule

FILE: design/tpg_point_mem.sv
// ----------------------------------------------------------------------------
// tpg_point_mem - point store, one row of points per slot
// Address is {slot, point}. One write port, one registered read port.
// ----------------------------------------------------------------------------
module tpg_point_mem (
  input  logic                  clk,
  input  tpg_pkg::point_req_t   req_i,
  output tpg_pkg::point_entry_t rdata_o
);

  localparam int DEPTH = tpg_pkg::NUM_SLOTS * tpg_pkg::POINTS_PER_SLOT;

  tpg_pkg::point_entry_t mem [DEPTH];
  tpg_pkg::point_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_r <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_r;

endmodule

FILE: design/tpg_seq.sv
// ----------------------------------------------------------------------------
// tpg_seq - item sequencer with one shared equality compare unit
// Scans slot ids, then the slot's point times, one memory read per cycle,
// and builds the result beat.
// ----------------------------------------------------------------------------
module tpg_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start_i,
  input  tpg_pkg::in_item_t     item_i,
  input  logic                  load_i,
  output logic                  idle_o,
  output logic                  done_o,
  output tpg_pkg::out_item_t    res_o,
  output tpg_pkg::slot_req_t    slot_req_o,
  input  tpg_pkg::slot_entry_t  slot_rdata_i,
  output tpg_pkg::point_req_t   pt_req_o,
  input  tpg_pkg::point_entry_t pt_rdata_i
);

  localparam int SLOT_W     = tpg_pkg::SLOT_W;
  localparam int PT_W       = tpg_pkg::PT_W;
  localparam int SLOT_CNT_W = tpg_pkg::SLOT_CNT_W;
  localparam int PT_CNT_W   = tpg_pkg::PT_CNT_W;
  localparam int SCAN_W     = tpg_pkg::SCAN_W;

  tpg_pkg::seq_state_t   state_r, state_nxt;
  tpg_pkg::in_item_t     item_r, item_nxt;
  logic [SLOT_CNT_W-1:0] used_r, used_nxt;
  logic [SCAN_W-1:0]     iss_r, iss_nxt;    // next index to read
  logic                  pend_r, pend_nxt;  // read data due this cycle
  logic [SCAN_W-1:0]     pidx_r, pidx_nxt;  // index of that read
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  tpg_pkg::slot_entry_t  ent_r, ent_nxt;
  logic                  fresh_r, fresh_nxt;
  tpg_pkg::out_item_t    res_r, res_nxt;

  // shared compare unit
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_eq;

  logic [PT_CNT_W-1:0]     cnt_inc;
  logic [tpg_pkg::DUP_W-1:0] dup_inc;
  logic                    repl;

  always_comb begin
    if (state_r == tpg_pkg::SEQ_SRCH) begin
      cmp_a = {16'd0, slot_rdata_i.id};
      cmp_b = {16'd0, item_r.target_id};
    end else begin
      cmp_a = pt_rdata_i.time_ms;
      cmp_b = item_r.time_ms;
    end
  end

  assign cmp_eq  = (cmp_a == cmp_b);
  assign cnt_inc = ent_r.cnt + PT_CNT_W'(1);
  assign dup_inc = (ent_r.dup == tpg_pkg::DUP_MAX) ? ent_r.dup : ent_r.dup + 16'd1;
  assign repl    = (item_r.range_m < pt_rdata_i.range_m);

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    used_nxt  = used_r;
    iss_nxt   = iss_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    slot_nxt  = slot_r;
    ent_nxt   = ent_r;
    fresh_nxt = fresh_r;
    res_nxt   = res_r;

    slot_req_o       = '0;
    slot_req_o.raddr = iss_r[SLOT_W-1:0];
    pt_req_o         = '0;
    pt_req_o.raddr   = {slot_r, iss_r[PT_W-1:0]};

    unique case (state_r)
      tpg_pkg::SEQ_IDLE: begin
        if (start_i) begin
          item_nxt = item_i;
          iss_nxt  = '0;
          pend_nxt = 1'b0;
          unique case (item_i.kind)
            tpg_pkg::KIND_PLOT: state_nxt = tpg_pkg::SEQ_SRCH;
            tpg_pkg::KIND_CLEAR: begin
              used_nxt       = '0;
              res_nxt        = '0;
              res_nxt.status = tpg_pkg::ST_CLEARED;
              state_nxt      = tpg_pkg::SEQ_DONE;
            end
            tpg_pkg::KIND_READ: state_nxt = tpg_pkg::SEQ_RD_SLOT;
            default: begin
              res_nxt              = '0;
              res_nxt.status       = tpg_pkg::ST_READ_BAD;
              res_nxt.slot_index   = item_i.read_slot;
              res_nxt.point_index  = item_i.read_point;
              res_nxt.target_count = used_r;
              state_nxt            = tpg_pkg::SEQ_DONE;
            end
          endcase
        end
      end

      tpg_pkg::SEQ_SRCH: begin
        // keep slot 0's entry; a table-full result reports it
        if (pend_r && pidx_r == '0) begin
          ent_nxt = slot_rdata_i;
        end
        if (pend_r && cmp_eq) begin
          slot_nxt  = pidx_r[SLOT_W-1:0];
          ent_nxt   = slot_rdata_i;
          fresh_nxt = 1'b0;
          iss_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = tpg_pkg::SEQ_PSCAN;
        end else if (iss_r < SCAN_W'(used_r)) begin
          pidx_nxt = iss_r;
          pend_nxt = 1'b1;
          iss_nxt  = iss_r + SCAN_W'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else if (used_r == SLOT_CNT_W'(tpg_pkg::NUM_SLOTS)) begin
          res_nxt                 = '0;
          res_nxt.status          = tpg_pkg::ST_NO_SLOT;
          res_nxt.target_count    = used_r;
          res_nxt.point_count     = ent_r.cnt;
          res_nxt.duplicate_count = ent_r.dup;
          res_nxt.out_target_id   = ent_r.id;
          state_nxt               = tpg_pkg::SEQ_DONE;
        end else begin
          // claim the next free slot; its entry is written on append
          slot_nxt  = used_r[SLOT_W-1:0];
          ent_nxt   = '0;
          ent_nxt.id = item_r.target_id;
          fresh_nxt = 1'b1;
          used_nxt  = used_r + SLOT_CNT_W'(1);
          iss_nxt   = '0;
          state_nxt = tpg_pkg::SEQ_PSCAN;
        end
      end

      tpg_pkg::SEQ_PSCAN: begin
        res_nxt                 = '0;
        res_nxt.slot_index      = slot_r;
        res_nxt.target_count    = used_r;
        res_nxt.out_target_id   = ent_r.id;
        res_nxt.point_count     = ent_r.cnt;
        res_nxt.duplicate_count = ent_r.dup;
        if (pend_r && cmp_eq) begin
          slot_req_o.we    = 1'b1;
          slot_req_o.waddr = slot_r;
          slot_req_o.wdata = '{id: ent_r.id, cnt: ent_r.cnt, dup: dup_inc};
          pt_req_o.waddr   = {slot_r, pidx_r[PT_W-1:0]};
          pt_req_o.wdata   = '{time_ms: pt_rdata_i.time_ms, range_m: item_r.range_m,
                               azimuth: item_r.azimuth};
          pt_req_o.we      = repl;
          res_nxt.status          = repl ? tpg_pkg::ST_DUP_REPL : tpg_pkg::ST_DUP_KEPT;
          res_nxt.point_index     = pidx_r[PT_W-1:0];
          res_nxt.duplicate_count = dup_inc;
          res_nxt.out_time_ms     = pt_rdata_i.time_ms;
          res_nxt.out_range_m     = repl ? item_r.range_m : pt_rdata_i.range_m;
          res_nxt.out_azimuth     = repl ? item_r.azimuth : pt_rdata_i.azimuth;
          state_nxt               = tpg_pkg::SEQ_DONE;
        end else if (iss_r < SCAN_W'(ent_r.cnt)) begin
          res_nxt  = res_r;
          pidx_nxt = iss_r;
          pend_nxt = 1'b1;
          iss_nxt  = iss_r + SCAN_W'(1);
        end else if (pend_r) begin
          res_nxt  = res_r;
          pend_nxt = 1'b0;
        end else if (ent_r.cnt == PT_CNT_W'(tpg_pkg::POINTS_PER_SLOT)) begin
          res_nxt.status = tpg_pkg::ST_PTS_FULL;
          state_nxt      = tpg_pkg::SEQ_DONE;
        end else begin
          pt_req_o.we      = 1'b1;
          pt_req_o.waddr   = {slot_r, ent_r.cnt[PT_W-1:0]};
          pt_req_o.wdata   = '{time_ms: item_r.time_ms, range_m: item_r.range_m,
                               azimuth: item_r.azimuth};
          slot_req_o.we    = 1'b1;
          slot_req_o.waddr = slot_r;
          slot_req_o.wdata = '{id: ent_r.id, cnt: cnt_inc, dup: ent_r.dup};
          res_nxt.status      = fresh_r ? tpg_pkg::ST_NEW_TARGET : tpg_pkg::ST_PT_ADDED;
          res_nxt.point_index = ent_r.cnt[PT_W-1:0];
          res_nxt.point_count = cnt_inc;
          res_nxt.out_time_ms = item_r.time_ms;
          res_nxt.out_range_m = item_r.range_m;
          res_nxt.out_azimuth = item_r.azimuth;
          state_nxt           = tpg_pkg::SEQ_DONE;
        end
      end

      tpg_pkg::SEQ_RD_SLOT: begin
        slot_req_o.raddr     = item_r.read_slot;
        res_nxt              = '0;
        res_nxt.status       = tpg_pkg::ST_READ_BAD;
        res_nxt.slot_index   = item_r.read_slot;
        res_nxt.point_index  = item_r.read_point;
        res_nxt.target_count = used_r;
        if (SLOT_CNT_W'(item_r.read_slot) < used_r) begin
          state_nxt = tpg_pkg::SEQ_RD_SLOT_W;
        end else begin
          state_nxt = tpg_pkg::SEQ_DONE;
        end
      end

      tpg_pkg::SEQ_RD_SLOT_W: begin
        pt_req_o.raddr = {item_r.read_slot, item_r.read_point};
        ent_nxt        = slot_rdata_i;
        if (PT_CNT_W'(item_r.read_point) < slot_rdata_i.cnt) begin
          state_nxt = tpg_pkg::SEQ_RD_PT_W;
        end else begin
          state_nxt = tpg_pkg::SEQ_DONE;
        end
      end

      tpg_pkg::SEQ_RD_PT_W: begin
        res_nxt.status          = tpg_pkg::ST_READ_OK;
        res_nxt.point_count     = ent_r.cnt;
        res_nxt.duplicate_count = ent_r.dup;
        res_nxt.out_target_id   = ent_r.id;
        res_nxt.out_time_ms     = pt_rdata_i.time_ms;
        res_nxt.out_range_m     = pt_rdata_i.range_m;
        res_nxt.out_azimuth     = pt_rdata_i.azimuth;
        state_nxt               = tpg_pkg::SEQ_DONE;
      end

      tpg_pkg::SEQ_DONE: begin
        if (load_i) begin
          state_nxt = tpg_pkg::SEQ_IDLE;
        end
      end

      default: state_nxt = tpg_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpg_pkg::SEQ_IDLE;
      used_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    iss_r   <= iss_nxt;
    pidx_r  <= pidx_nxt;
    slot_r  <= slot_nxt;
    ent_r   <= ent_nxt;
    fresh_r <= fresh_nxt;
    res_r   <= res_nxt;
  end

  assign idle_o = (state_r == tpg_pkg::SEQ_IDLE);
  assign done_o = (state_r == tpg_pkg::SEQ_DONE);
  assign res_o  = res_r;

  // Assertions
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= SLOT_CNT_W'(tpg_pkg::NUM_SLOTS))
    else $error("slots in use above table size");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpg_pkg::SEQ_PSCAN) |-> (ent_r.cnt <= PT_CNT_W'(tpg_pkg::POINTS_PER_SLOT)))
    else $error("slot point count above store size");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (idle_o && start_i && item_i.kind == tpg_pkg::KIND_CLEAR) |=> (used_r == '0))
    else $error("clear did not empty the table");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (done_o && load_i) |=> idle_o)
    else $error("sequencer did not return to idle after result beat");

endmodule

FILE: design/target_point_grouping_table.sv
// ----------------------------------------------------------------------------
// target_point_grouping_table - radar plot grouping table, top level
// Input beat register handshake, sequencer, slot and point memories,
// output register.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_ready is high only while the sequencer is
// idle, and each item gives exactly one result beat. A plot record walks the
// slot ids in use one per cycle through the slot memory read port and one
// shared compare, then walks that slot's stored point times one per cycle
// through the point memory read port. Clear and unused kinds go straight to
// the result; a read item reads its slot entry, then its point if both
// indexes are in range. The result sits in an output register, so the next
// item is taken while the previous result still waits for out_ready. The
// memories have no reset and no clearing pass: only entries already written
// are ever read. Clear just drops the slots-in-use count.
// ----------------------------------------------------------------------------
module target_point_grouping_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tpg_pkg::out_item_t out_data
);

  logic                  seq_idle;
  logic                  seq_done;
  logic                  start;
  logic                  out_load;
  tpg_pkg::out_item_t    seq_res;

  tpg_pkg::slot_req_t    slot_req;
  tpg_pkg::slot_entry_t  slot_rdata;
  tpg_pkg::point_req_t   pt_req;
  tpg_pkg::point_entry_t pt_rdata;

  logic                  out_valid_r, out_valid_nxt;
  tpg_pkg::out_item_t    out_data_r;

  // accept a new beat only while the sequencer is idle
  assign in_ready = seq_idle;
  assign start    = in_valid & in_ready;

  // result moves into the output register when it is empty or draining
  assign out_load      = seq_done & (~out_valid_r | out_ready);
  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  tpg_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (start),
    .item_i       (in_data),
    .load_i       (out_load),
    .idle_o       (seq_idle),
    .done_o       (seq_done),
    .res_o        (seq_res),
    .slot_req_o   (slot_req),
    .slot_rdata_i (slot_rdata),
    .pt_req_o     (pt_req),
    .pt_rdata_i   (pt_rdata)
  );

  tpg_slot_mem u_slot_mem (
    .clk     (clk),
    .req_i   (slot_req),
    .rdata_o (slot_rdata)
  );

  tpg_point_mem u_point_mem (
    .clk     (clk),
    .req_i   (pt_req),
    .rdata_o (pt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: test/target_point_grouping_table_tb.sv
// ----------------------------------------------------------------------------
// target_point_grouping_table_tb - testbench for the plot grouping table
// Drives plot, clear, read and spare-kind beats through the valid/ready
// input, predicts each result beat with an internal model of the slot table,
// and checks every result beat field by field in order.
// ----------------------------------------------------------------------------
module target_point_grouping_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Kind code that the block does not define; it answers like a bad read.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Cycles with no beat on either side before the run is declared hung.
  // The limit sits well above the slowest record plus the random gaps and stalls.
  localparam int HANG_LIMIT = 5000;
  // Quiet cycles after the last expected result, to catch stray beats.
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1000;

  localparam int NSLOT = tpg_pkg::NUM_SLOTS;
  localparam int NPT   = tpg_pkg::POINTS_PER_SLOT;

  // --------------------------------------------------------------------------
  // Table model and result checker
  // --------------------------------------------------------------------------
  class plot_table_scoreboard;
    int                 targets_in_use;
    logic [15:0]        slot_id     [NSLOT];
    logic [6:0]         slot_points [NSLOT];
    logic [15:0]        slot_dups   [NSLOT];
    logic [31:0]        pt_time     [NSLOT*NPT];
    logic [23:0]        pt_range    [NSLOT*NPT];
    logic [15:0]        pt_azimuth  [NSLOT*NPT];
    tpg_pkg::out_item_t expected_results[$];
    int                 mismatches;

    function new();
      targets_in_use = 0;
      mismatches     = 0;
      foreach (slot_id[i]) begin
        slot_id[i]     = '0;
        slot_points[i] = '0;
        slot_dups[i]   = '0;
      end
      foreach (pt_time[i]) begin
        pt_time[i]    = '0;
        pt_range[i]   = '0;
        pt_azimuth[i] = '0;
      end
    endfunction

    // Slot bookkeeping is reported for any slot in use and any status up to
    // read ok; point fields only when a point was touched or read.
    function tpg_pkg::out_item_t make_result(logic [3:0] st, int slot, int pt,
                                             bit with_point);
      tpg_pkg::out_item_t r;
      int                 a;
      r              = '0;
      r.status       = st;
      r.slot_index   = 5'(slot);
      r.point_index  = 6'(pt);
      r.target_count = 6'(targets_in_use);
      if (slot < targets_in_use && st <= tpg_pkg::ST_READ_OK) begin
        r.point_count     = slot_points[slot];
        r.duplicate_count = slot_dups[slot];
        r.out_target_id   = slot_id[slot];
        if (with_point) begin
          a             = slot * NPT + pt;
          r.out_time_ms = pt_time[a];
          r.out_range_m = pt_range[a];
          r.out_azimuth = pt_azimuth[a];
        end
      end
      return r;
    endfunction

    function tpg_pkg::out_item_t apply_plot(tpg_pkg::in_item_t it);
      int         s;
      int         n;
      int         base;
      bit         fresh;
      logic [3:0] st;
      s     = targets_in_use;
      fresh = 1'b0;
      for (int i = 0; i < targets_in_use; i++) begin
        if (slot_id[i] == it.target_id) begin
          s = i;
          break;
        end
      end
      if (s == targets_in_use) begin
        // unknown id: claim next slot or drop when the table is full
        if (targets_in_use >= NSLOT) return make_result(tpg_pkg::ST_NO_SLOT, 0, 0, 1'b0);
        slot_id[s]     = it.target_id;
        slot_points[s] = '0;
        slot_dups[s]   = '0;
        targets_in_use++;
        fresh = 1'b1;
      end
      base = s * NPT;
      n    = int'(slot_points[s]);
      for (int p = 0; p < n; p++) begin
        if (pt_time[base+p] == it.time_ms) begin
          st = tpg_pkg::ST_DUP_KEPT;
          if (slot_dups[s] != tpg_pkg::DUP_MAX) slot_dups[s] = slot_dups[s] + 16'd1;
          if (it.range_m < pt_range[base+p]) begin
            pt_range[base+p]   = it.range_m;
            pt_azimuth[base+p] = it.azimuth;
            st                 = tpg_pkg::ST_DUP_REPL;
          end
          return make_result(st, s, p, 1'b1);
        end
      end
      if (n >= NPT) return make_result(tpg_pkg::ST_PTS_FULL, s, 0, 1'b0);
      pt_time[base+n]    = it.time_ms;
      pt_range[base+n]   = it.range_m;
      pt_azimuth[base+n] = it.azimuth;
      slot_points[s]     = 7'(n + 1);
      return make_result(fresh ? tpg_pkg::ST_NEW_TARGET : tpg_pkg::ST_PT_ADDED,
                         s, n, 1'b1);
    endfunction

    // Called once per accepted input beat.
    function void note_item(tpg_pkg::in_item_t it);
      tpg_pkg::out_item_t r;
      int                 rs;
      int                 rp;
      rs = int'(it.read_slot);
      rp = int'(it.read_point);
      case (it.kind)
        tpg_pkg::KIND_PLOT: r = apply_plot(it);
        tpg_pkg::KIND_CLEAR: begin
          targets_in_use = 0;
          r              = '0;
          r.status       = tpg_pkg::ST_CLEARED;
        end
        default: begin
          if (it.kind == tpg_pkg::KIND_READ && rs < targets_in_use &&
              rp < int'(slot_points[rs]))
            r = make_result(tpg_pkg::ST_READ_OK, rs, rp, 1'b1);
          else
            r = make_result(tpg_pkg::ST_READ_BAD, rs, rp, 1'b0);
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Called once per accepted result beat.
    function void check_result(tpg_pkg::out_item_t got);
      tpg_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing pending: status %0h", got.status);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      cmp_field("status",          want.status,          got.status);
      cmp_field("slot_index",      want.slot_index,      got.slot_index);
      cmp_field("point_index",     want.point_index,     got.point_index);
      cmp_field("point_count",     want.point_count,     got.point_count);
      cmp_field("duplicate_count", want.duplicate_count, got.duplicate_count);
      cmp_field("target_count",    want.target_count,    got.target_count);
      cmp_field("out_target_id",   want.out_target_id,   got.out_target_id);
      cmp_field("out_time_ms",     want.out_time_ms,     got.out_time_ms);
      cmp_field("out_range_m",     want.out_range_m,     got.out_range_m);
      cmp_field("out_azimuth",     want.out_azimuth,     got.out_azimuth);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  tpg_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tpg_pkg::out_item_t out_data;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  target_point_grouping_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  plot_table_scoreboard sb = new();

  bit idling_on   = 1'b1;  // random gaps/stalls enabled for this stretch
  int items_sent  = 0;
  int stall_left  = 0;
  int hang_cycles = 0;

  // --------------------------------------------------------------------------
  // Result side: check every accepted beat, stall out_ready in random bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any beat on either side restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      hang_cycles <= 0;
    else
      hang_cycles <= hang_cycles + 1;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Every field random; callers overwrite what matters for the kind, so the
  // unused fields carry noise.
  function automatic tpg_pkg::in_item_t random_item();
    tpg_pkg::in_item_t it;
    it.kind       = 2'($urandom);
    it.target_id  = 16'($urandom);
    it.time_ms    = $urandom;
    it.range_m    = 24'($urandom);
    it.azimuth    = 16'($urandom);
    it.read_slot  = 5'($urandom);
    it.read_point = 6'($urandom);
    return it;
  endfunction

  // Optional gap, then hold valid and payload until the beat is taken.
  // Valid is only lowered by a gap, so back-to-back beats keep it high.
  task automatic push_item(input tpg_pkg::in_item_t it);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_plot(input logic [15:0] id, input logic [31:0] t,
                           input logic [23:0] rng, input logic [15:0] az);
    tpg_pkg::in_item_t it;
    it           = random_item();
    it.kind      = tpg_pkg::KIND_PLOT;
    it.target_id = id;
    it.time_ms   = t;
    it.range_m   = rng;
    it.azimuth   = az;
    push_item(it);
  endtask

  task automatic send_read(input logic [1:0] k, input int slot, input int pt);
    tpg_pkg::in_item_t it;
    it            = random_item();
    it.kind       = k;
    it.read_slot  = 5'(slot);
    it.read_point = 6'(pt);
    push_item(it);
  endtask

  task automatic send_clear();
    tpg_pkg::in_item_t it;
    it      = random_item();
    it.kind = tpg_pkg::KIND_CLEAR;
    push_item(it);
  endtask

  // Read a point that is actually stored, when there is one.
  task automatic send_stored_read();
    int s;
    if (sb.targets_in_use == 0) begin
      send_read(tpg_pkg::KIND_READ, $urandom_range(0, 31), $urandom_range(0, 63));
    end else begin
      s = $urandom_range(0, sb.targets_in_use - 1);
      send_read(tpg_pkg::KIND_READ, s, $urandom_range(0, int'(sb.slot_points[s]) - 1));
    end
  endtask

  // Plots from a small id pool over a narrow time window, so new targets,
  // added points and duplicates all show up; reads, clears and noise mixed in.
  // Without a clear the pool piles onto earlier episodes and fills the table.
  task automatic mixed_episode();
    logic [15:0] ids [40];
    logic [31:0] t0;
    int          pool;
    int          span;
    int          pick;
    pool = $urandom_range(1, 40);
    span = $urandom_range(1, 80);
    t0   = $urandom;
    foreach (ids[i]) ids[i] = 16'($urandom);
    if ($urandom_range(0, 1) == 0) send_clear();
    repeat ($urandom_range(20, 80)) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_plot(ids[$urandom_range(0, pool - 1)], t0 + 32'($urandom_range(0, span - 1)),
                  24'($urandom), 16'($urandom));
      else if (pick < 85)
        send_stored_read();
      else if (pick < 92)
        send_read(tpg_pkg::KIND_READ, $urandom_range(0, 31), $urandom_range(0, 63));
      else if (pick < 95)
        send_read(KIND_SPARE, $urandom_range(0, 31), $urandom_range(0, 63));
      else if (pick < 97)
        send_clear();
      else
        push_item(random_item());
    end
  endtask

  // One target driven past its point store limit, with duplicates of
  // earlier times sprinkled in (those still match once the store is full).
  task automatic fill_slot_episode();
    logic [15:0] id;
    logic [31:0] t0;
    int          fresh_t;
    int          pick;
    id      = 16'($urandom);
    t0      = $urandom;
    fresh_t = 0;
    if ($urandom_range(0, 1) == 0) send_clear();
    repeat (100) begin
      pick = $urandom_range(0, 99);
      if (pick < 20 && fresh_t > 0)
        send_plot(id, t0 + 32'($urandom_range(0, fresh_t - 1)), 24'($urandom), 16'($urandom));
      else if (pick < 30)
        send_stored_read();
      else begin
        send_plot(id, t0 + 32'(fresh_t), 24'($urandom), 16'($urandom));
        fresh_t++;
      end
    end
  endtask

  // More distinct ids than slots: the last few find no free slot.
  task automatic fill_table_episode();
    int base_id;
    base_id = $urandom_range(0, 65535);
    send_clear();
    for (int i = 0; i < NSLOT + 4; i++)
      send_plot(16'(base_id + i), $urandom, 24'($urandom), 16'($urandom));
    repeat (10) begin
      if ($urandom_range(0, 1) == 0)
        send_plot(16'(base_id + $urandom_range(0, NSLOT + 3)), $urandom,
                  24'($urandom), 16'($urandom));
      else
        send_stored_read();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int         directed_items;
    logic [15:0] sat_id;
    logic [31:0] sat_t;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table reads, field extremes, every status code but no-slot and points-full.
    send_read(tpg_pkg::KIND_READ, 31, 63);                         // empty table
    send_read(KIND_SPARE, 0, 0);                                   // spare kind
    send_plot(16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF);     // new target
    send_plot(16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'h0000);     // dup, equal range kept
    send_plot(16'hFFFF, 32'hFFFF_FFFF, 24'h00_0000, 16'h0000);     // dup, smaller replaces
    send_plot(16'hFFFF, 32'h0000_0000, 24'h00_0000, 16'hFFFF);     // point added
    send_plot(16'h0000, 32'h0000_0000, 24'hFF_FFFF, 16'h0000);     // second slot
    send_plot(16'h0000, 32'h0000_0000, 24'h00_0001, 16'h1234);     // dup replaced
    send_read(tpg_pkg::KIND_READ, 0, 1);                           // read ok
    send_read(tpg_pkg::KIND_READ, 0, 2);                           // point past count
    send_read(tpg_pkg::KIND_READ, 2, 0);                           // slot not in use
    send_read(tpg_pkg::KIND_READ, 1, 0);                           // read ok
    send_read(KIND_SPARE, 1, 0);                                   // spare kind, valid indexes
    send_clear();
    send_read(tpg_pkg::KIND_READ, 0, 0);                           // after clear
    send_plot(16'h1234, 32'h0000_0000, 24'h00_0005, 16'h0005);     // slot 0 reclaimed
    send_read(tpg_pkg::KIND_READ, 0, 0);
    directed_items = items_sent;

    // Random episodes; some stretches run without gaps or stalls.
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      idling_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        3:       fill_slot_episode();
        4:       fill_table_episode();
        5:       repeat (20) push_item(random_item());
        default: mixed_episode();
      endcase
    end

    // Last part, no idling: one point duplicated back to back so its
    // counter climbs, a read of it, then one more point on that target.
    idling_on = 1'b0;
    sat_id    = 16'($urandom);
    sat_t     = $urandom;
    send_clear();
    send_plot(sat_id, sat_t, 24'hFF_FFFF, 16'($urandom));
    repeat (20)
      send_plot(sat_id, sat_t, 24'($urandom), 16'($urandom));
    send_read(tpg_pkg::KIND_READ, 0, 0);
    send_plot(sat_id, sat_t + 32'd1, 24'($urandom), 16'($urandom));
    in_valid <= 1'b0;

    // Drain, then watch for stray beats.
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
